// ===== design/pid_controller_antiwindup_core_macros.svh =====
// Assertion helpers, clocked on i_clk, off while i_rst_n is low.
`ifndef PID_CONTROLLER_ANTIWINDUP_CORE_MACROS_SVH
`define PID_CONTROLLER_ANTIWINDUP_CORE_MACROS_SVH

// same-cycle implication
`define PIDAW_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pidaw assertion failed");

// next-cycle implication
`define PIDAW_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pidaw assertion failed");

`endif

// ===== design/pidaw_pkg.sv =====
package pidaw_pkg;

    localparam int W          = 32;
    localparam int FRAC       = 16;
    localparam int MS_W       = 16;
    localparam int LIM_W      = W - 1;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = W;
    localparam int CFG_IDX_W  = 3;
    localparam int OPW        = W + 1;
    localparam int PROD_W     = 2 * OPW;
    localparam int DIV_W      = 48;
    localparam int DIV_CNT_W  = $clog2(DIV_W + 1);
    localparam int ACC_W      = W + 2;
    localparam int DIV_K      = 1000;

    // divide by 1000: x = xh*2^24 + xl and 2^24 = 16777*1000 + 216, so
    // x/1000 = xh*16777 + (xh*216 + xl)/1000; the last term as (z>>3)/125
    // by reciprocal, exact for z below 2^31
    localparam int K_SPLIT  = 24;
    localparam int K_HI_W   = 23;
    localparam int K_Z_W    = 31;
    localparam int K_PRE_SH = 3;
    localparam int K_HQ_W   = 38;
    localparam int K_T_W    = 58;
    localparam int K_RCP_SH = 36;
    localparam int K_ZQ_W   = K_T_W - K_RCP_SH;
    localparam logic [K_HQ_W-1:0] K_HI_Q = K_HQ_W'((1 << K_SPLIT) / DIV_K);
    localparam logic [K_Z_W-1:0]  K_HI_R = K_Z_W'((1 << K_SPLIT) % DIV_K);
    localparam logic [K_T_W-1:0]  K_RCP  = K_T_W'(549755814);  // ceil(2^36 / 125)

    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CEILING    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_LIM  = 3'd6;

    localparam logic signed [W-1:0] RST_PROP_GAIN  = W'(65536);
    localparam logic signed [W-1:0] RST_INTEG_GAIN = W'(6554);
    localparam logic signed [W-1:0] RST_DERIV_GAIN = W'(3277);
    localparam logic signed [W-1:0] RST_TARGET     = W'(0);
    localparam logic signed [W-1:0] RST_FLOOR      = W'(-65536000);
    localparam logic signed [W-1:0] RST_CEILING    = W'(65536000);
    localparam logic [LIM_W-1:0]    RST_INTEG_LIM  = LIM_W'(6553600);

    // multiplier operand select
    localparam logic [2:0] MUL_ERR_MS = 3'd0;
    localparam logic [2:0] MUL_DIFF_K = 3'd1;
    localparam logic [2:0] MUL_KP     = 3'd2;
    localparam logic [2:0] MUL_KI     = 3'd3;
    localparam logic [2:0] MUL_KD     = 3'd4;

    localparam logic signed [PROD_W-1:0] P_WMAX = {{(PROD_W-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [PROD_W-1:0] P_WMIN = {{(PROD_W-W+1){1'b1}}, {(W-1){1'b0}}};

    typedef struct packed {
        logic       load;
        logic       calc_err;
        logic       mul_en;
        logic [2:0] mul_sel;
        logic       div_load;
        logic       save_integ;
        logic       save_deriv;
        logic       acc_clr;
        logic       acc_add;
        logic       out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic ms_zero;
        logic div_busy;
        logic out_free;
    } t_dp_sts;

    function automatic logic signed [W-1:0] sat_w(input logic signed [PROD_W-1:0] v);
        logic signed [W-1:0] res;
        if (v > P_WMAX) begin
            res = {1'b0, {(W-1){1'b1}}};
        end else if (v < P_WMIN) begin
            res = {1'b1, {(W-1){1'b0}}};
        end else begin
            res = v[W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== design/pid_controller_antiwindup_core.sv =====
// One item in flight at a time: no new input is taken until the result
// of the last one is loaded into the output register. The radix-2 divide
// by elapsed_ms (48 steps) is skipped when elapsed_ms is zero; a stalled
// output delays the result and the next input.
// Reset (i_rst_n low, synchronous): gains and limits to defaults, integral,
// prior error and last output cleared, output channel empty.
module pid_controller_antiwindup_core import pidaw_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,   // [31:0] measured_value, [47:32] elapsed_ms
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]  m_axis_tdata,   // [31:0] drive_value
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [W-1:0]          i_cfg_wdata
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    pidaw_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_sts     (w_sts),
        .o_cmd     (w_cmd)
    );

    pidaw_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_s_data    (s_axis_tdata),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_m_ready   (m_axis_tready),
        .o_m_valid   (m_axis_tvalid),
        .o_m_data    (m_axis_tdata)
    );

endmodule

// ===== design/pidaw_div.sv =====
module pidaw_div import pidaw_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  logic [DIV_W-1:0]   i_dividend,
    input  logic [MS_W-1:0]    i_divisor,
    output logic [DIV_W-1:0]   o_quot,
    output logic               o_busy
);

    logic [MS_W-1:0]      r_rem;
    logic [DIV_W-1:0]     r_quo;
    logic [MS_W-1:0]      r_dvs;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic [MS_W:0]        w_trial;
    logic [MS_W:0]        w_sub;
    logic                 w_ge;

    // restoring divide, one quotient bit per cycle
    assign w_trial = {r_rem, r_quo[DIV_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_dvs};
    assign w_sub   = w_trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_cnt  <= DIV_CNT_W'(DIV_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == DIV_CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_sub[MS_W-1:0] : w_trial[MS_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], w_ge};
        end
    end

    assign o_quot = r_quo;
    assign o_busy = r_busy;

endmodule

// ===== design/pidaw_dp.sv =====
module pidaw_dp import pidaw_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    input  logic [S_TDATA_W-1:0]  i_s_data,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [W-1:0]          i_cfg_wdata,
    input  logic                  i_m_ready,
    output logic                  o_m_valid,
    output logic [M_TDATA_W-1:0]  o_m_data
);

    logic signed [W-1:0]      r_kp, r_ki, r_kd, r_target, r_floor, r_ceil;
    logic [LIM_W-1:0]         r_lim;
    logic signed [W-1:0]      r_meas;
    logic [MS_W-1:0]          r_ms;
    logic signed [W-1:0]      r_err, r_integ, r_deriv;
    logic signed [W-1:0]      r_isum, r_prior, r_last;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_neg;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_out_valid;
    logic [W-1:0]             r_out_data;
    logic [K_Z_W-1:0]         r_kz;
    logic [K_HQ_W-1:0]        r_kh;
    logic [K_ZQ_W-1:0]        r_kzq;
    logic [DIV_W-1:0]         r_kq;

    logic signed [W:0]        w_err_dif;
    logic signed [OPW-1:0]    w_diff;
    logic signed [OPW-1:0]    w_a, w_b;
    logic signed [PROD_W-1:0] w_mul;
    logic signed [PROD_W-1:0] w_prod_mag;
    logic [K_HI_W-1:0]        w_k_hi;
    logic [K_T_W-1:0]         w_k_t;
    logic [DIV_W-1:0]         w_q;
    logic                     w_div_busy;
    logic signed [DIV_W:0]    w_qs;
    logic signed [DIV_W:0]    w_inc;
    logic signed [DIV_W:0]    w_isum_new;
    logic signed [DIV_W:0]    w_lim_pos, w_lim_neg;
    logic signed [W-1:0]      w_integ;
    logic signed [PROD_W-1:0] w_shift;
    logic signed [W-1:0]      w_term;
    logic signed [ACC_W-1:0]  w_term_x;
    logic signed [ACC_W-1:0]  w_ceil_x, w_floor_x, w_hi_clip, w_clip;
    logic                     w_ms_zero;
    logic signed [W-1:0]      w_drive;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp     <= RST_PROP_GAIN;
            r_ki     <= RST_INTEG_GAIN;
            r_kd     <= RST_DERIV_GAIN;
            r_target <= RST_TARGET;
            r_floor  <= RST_FLOOR;
            r_ceil   <= RST_CEILING;
            r_lim    <= RST_INTEG_LIM;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                CFG_PROP_GAIN:  r_kp     <= i_cfg_wdata;
                CFG_INTEG_GAIN: r_ki     <= i_cfg_wdata;
                CFG_DERIV_GAIN: r_kd     <= i_cfg_wdata;
                CFG_TARGET:     r_target <= i_cfg_wdata;
                CFG_FLOOR:      r_floor  <= i_cfg_wdata;
                CFG_CEILING:    r_ceil   <= i_cfg_wdata;
                CFG_INTEG_LIM:  r_lim    <= i_cfg_wdata[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_ms_zero = (r_ms == '0);
    assign w_err_dif = {r_target[W-1], r_target} - {r_meas[W-1], r_meas};
    assign w_diff    = {r_err[W-1], r_err} - {r_prior[W-1], r_prior};

    always_comb begin
        case (i_cmd.mul_sel)
            MUL_ERR_MS: begin
                w_a = {r_err[W-1], r_err};
                w_b = {{(OPW-MS_W){1'b0}}, r_ms};
            end
            MUL_DIFF_K: begin
                w_a = w_diff;
                w_b = OPW'(DIV_K);
            end
            MUL_KP: begin
                w_a = {r_kp[W-1], r_kp};
                w_b = {r_err[W-1], r_err};
            end
            MUL_KI: begin
                w_a = {r_ki[W-1], r_ki};
                w_b = {r_integ[W-1], r_integ};
            end
            MUL_KD: begin
                w_a = {r_kd[W-1], r_kd};
                w_b = {r_deriv[W-1], r_deriv};
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    assign w_mul      = w_a * w_b;
    assign w_prod_mag = r_prod[PROD_W-1] ? -r_prod : r_prod;

    // |e*ms| / 1000 in three register stages, magnitude below 2^47
    assign w_k_hi = w_prod_mag[K_SPLIT+K_HI_W-1:K_SPLIT];
    assign w_k_t  = K_T_W'(r_kz[K_Z_W-1:K_PRE_SH]) * K_RCP;

    always_ff @(posedge i_clk) begin
        r_kz  <= K_Z_W'(w_k_hi) * K_HI_R + K_Z_W'(w_prod_mag[K_SPLIT-1:0]);
        r_kh  <= K_HQ_W'(w_k_hi) * K_HI_Q;
        r_kzq <= w_k_t[K_T_W-1:K_RCP_SH];
        r_kq  <= DIV_W'(r_kh) + DIV_W'(r_kzq);
    end

    // |(e - prior)*1000| / elapsed_ms
    pidaw_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (i_cmd.div_load),
        .i_dividend (w_prod_mag[DIV_W-1:0]),
        .i_divisor  (r_ms),
        .o_quot     (w_q),
        .o_busy     (w_div_busy)
    );

    // signed quotients, integral update with clamp
    assign w_qs       = r_neg ? -{1'b0, w_q} : {1'b0, w_q};
    assign w_inc      = r_err[W-1] ? -{1'b0, r_kq} : {1'b0, r_kq};
    assign w_isum_new = w_inc + {{(DIV_W+1-W){r_isum[W-1]}}, r_isum};
    assign w_lim_pos  = {{(DIV_W+1-LIM_W){1'b0}}, r_lim};
    assign w_lim_neg  = -w_lim_pos;

    always_comb begin
        if (w_isum_new > w_lim_pos) begin
            w_integ = w_lim_pos[W-1:0];
        end else if (w_isum_new < w_lim_neg) begin
            w_integ = w_lim_neg[W-1:0];
        end else begin
            w_integ = w_isum_new[W-1:0];
        end
    end

    // gain term: floor shift, saturate
    assign w_shift  = r_prod >>> FRAC;
    assign w_term   = sat_w(w_shift);
    assign w_term_x = {{(ACC_W-W){w_term[W-1]}}, w_term};

    // output clamp, floor wins
    assign w_ceil_x  = {{(ACC_W-W){r_ceil[W-1]}}, r_ceil};
    assign w_floor_x = {{(ACC_W-W){r_floor[W-1]}}, r_floor};
    assign w_hi_clip = (r_acc > w_ceil_x) ? w_ceil_x : r_acc;
    assign w_clip    = (w_hi_clip < w_floor_x) ? w_floor_x : w_hi_clip;
    assign w_drive   = w_ms_zero ? r_last : w_clip[W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_meas <= i_s_data[W-1:0];
            r_ms   <= i_s_data[W+MS_W-1:W];
        end
        if (i_cmd.calc_err) begin
            r_err <= sat_w({{(PROD_W-W-1){w_err_dif[W]}}, w_err_dif});
        end
        if (i_cmd.mul_en) begin
            r_prod <= w_mul;
        end
        if (i_cmd.div_load) begin
            r_neg <= r_prod[PROD_W-1];
        end
        if (i_cmd.save_integ) begin
            r_integ <= w_integ;
        end
        if (i_cmd.save_deriv) begin
            r_deriv <= sat_w({{(PROD_W-DIV_W-1){w_qs[DIV_W]}}, w_qs});
        end
        if (i_cmd.acc_clr) begin
            r_acc <= w_term_x;
        end else if (i_cmd.acc_add) begin
            r_acc <= r_acc + w_term_x;
        end
        if (i_cmd.out_load) begin
            r_out_data <= w_drive;
        end
    end

    // controller state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_isum      <= '0;
            r_prior     <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.out_load && !w_ms_zero) begin
                r_isum  <= r_integ;
                r_prior <= r_err;
                r_last  <= w_clip[W-1:0];
            end
        end
    end

    assign o_sts.ms_zero  = w_ms_zero;
    assign o_sts.div_busy = w_div_busy;
    assign o_sts.out_free = !r_out_valid || i_m_ready;
    assign o_m_valid      = r_out_valid;
    assign o_m_data       = r_out_data;

endmodule

// ===== design/pidaw_ctrl.sv =====
module pidaw_ctrl import pidaw_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_valid,
    output logic    o_s_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_CHECK = 4'd1;
    localparam logic [3:0] ST_MUL_I = 4'd2;
    localparam logic [3:0] ST_RCP_1 = 4'd3;
    localparam logic [3:0] ST_RCP_2 = 4'd4;
    localparam logic [3:0] ST_RCP_3 = 4'd5;
    localparam logic [3:0] ST_INTEG = 4'd6;
    localparam logic [3:0] ST_LDV_D = 4'd7;
    localparam logic [3:0] ST_DIV_D = 4'd8;
    localparam logic [3:0] ST_DERIV = 4'd9;
    localparam logic [3:0] ST_TRM_I = 4'd10;
    localparam logic [3:0] ST_TRM_D = 4'd11;
    localparam logic [3:0] ST_SUM   = 4'd12;
    localparam logic [3:0] ST_DONE  = 4'd13;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        o_cmd     = '0;
        o_s_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CHECK;
                end
            end
            ST_CHECK: begin
                o_cmd.calc_err = 1'b1;
                n_state = i_sts.ms_zero ? ST_DONE : ST_MUL_I;
            end
            ST_MUL_I: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_ERR_MS;
                n_state       = ST_RCP_1;
            end
            // divide by 1000 pipeline fills
            ST_RCP_1: begin
                n_state = ST_RCP_2;
            end
            ST_RCP_2: begin
                n_state = ST_RCP_3;
            end
            ST_RCP_3: begin
                n_state = ST_INTEG;
            end
            ST_INTEG: begin
                o_cmd.save_integ = 1'b1;
                o_cmd.mul_en     = 1'b1;
                o_cmd.mul_sel    = MUL_DIFF_K;
                n_state          = ST_LDV_D;
            end
            ST_LDV_D: begin
                o_cmd.div_load = 1'b1;
                n_state        = ST_DIV_D;
            end
            ST_DIV_D: begin
                if (!i_sts.div_busy) begin
                    n_state = ST_DERIV;
                end
            end
            ST_DERIV: begin
                o_cmd.save_deriv = 1'b1;
                o_cmd.mul_en     = 1'b1;
                o_cmd.mul_sel    = MUL_KP;
                n_state          = ST_TRM_I;
            end
            ST_TRM_I: begin
                o_cmd.acc_clr = 1'b1;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_KI;
                n_state       = ST_TRM_D;
            end
            ST_TRM_D: begin
                o_cmd.acc_add = 1'b1;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_KD;
                n_state       = ST_SUM;
            end
            ST_SUM: begin
                o_cmd.acc_add = 1'b1;
                n_state       = ST_DONE;
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/pidaw_checker.sv =====
`include "pid_controller_antiwindup_core_macros.svh"

module pidaw_checker import pidaw_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic [S_TDATA_W-1:0] s_axis_tdata,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata
);

    // one item at a time: input closes right after an accept
    `PIDAW_ASSERT_NXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // zero elapsed time with an empty output gives a result via the check and done states
    `PIDAW_ASSERT_IMP(a_zero_dt_fast, s_axis_tvalid && s_axis_tready && (s_axis_tdata[47:32] == 16'd0) && !m_axis_tvalid, ##3 m_axis_tvalid)

    `PIDAW_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

    `PIDAW_ASSERT_NXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))

endmodule

bind pid_controller_antiwindup_core pidaw_checker u_pidaw_checker (.*);
